// ===== hw/rtl/delivery_predictability_table_macros.svh =====
// assertion macros for the delivery predictability table
`ifndef DELIVERY_PREDICTABILITY_TABLE_MACROS_SVH
`define DELIVERY_PREDICTABILITY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define DPT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DPT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DPT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define DPT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dpt_pkg.sv =====
// shared constants, types and helpers of the delivery predictability table
`default_nettype none
package dpt_pkg;
   localparam int NODES     = 16;
   localparam int COLS      = NODES + 1;
   localparam int CELLS     = NODES * COLS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int PROB_BITS = 16;
   localparam int STAMP_W   = 32;
   localparam int WORD_W    = STAMP_W + PROB_BITS;
   localparam logic [PROB_BITS:0] PONE = {1'b1, {PROB_BITS{1'b0}}};

   localparam logic [2:0] MODE_INIT  = 3'd0;
   localparam logic [2:0] MODE_TICK  = 3'd1;
   localparam logic [2:0] MODE_ENC   = 3'd2;
   localparam logic [2:0] MODE_SINK  = 3'd3;
   localparam logic [2:0] MODE_QUERY = 3'd4;

   localparam logic [2:0] CSR_REINF_PRED   = 3'd0;
   localparam logic [2:0] CSR_DECAY_PRED   = 3'd1;
   localparam logic [2:0] CSR_TRANS_PRED   = 3'd2;
   localparam logic [2:0] CSR_STRICT_TIE   = 3'd3;
   localparam logic [2:0] CSR_AGE_INTERVAL = 3'd4;

   localparam logic [15:0] RST_REINF_PRED   = 16'd49152;
   localparam logic [15:0] RST_DECAY_PRED   = 16'd64225;
   localparam logic [15:0] RST_TRANS_PRED   = 16'd16384;
   localparam logic        RST_STRICT_TIE   = 1'b1;
   localparam logic [15:0] RST_AGE_INTERVAL = 16'd60;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [15:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
      logic [15:0] rem;
   } div_rsp_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [3:0] row,
                                                   input logic [4:0] col);
      return ADDR_W'(32'(row) * COLS + 32'(col));
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/dpt_if.sv =====
// request and response channel interfaces
`default_nettype none
interface dpt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [3:0]  node_a;
   logic [3:0]  node_b;
   logic [31:0] now;
   logic [15:0] alive_mask;
   logic        coin;
   modport source (output valid, mode, node_a, node_b, now, alive_mask, coin, input ready);
   modport sink (input valid, mode, node_a, node_b, now, alive_mask, coin, output ready);
endinterface

interface dpt_rsp_if;
   logic        valid;
   logic        ready;
   logic        forward;
   logic [15:0] pred_a_sink;
   modport source (output valid, forward, pred_a_sink, input ready);
   modport sink (input valid, forward, pred_a_sink, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dpt_mem.sv =====
// table memory: predictability and stamp per cell, registered read
`default_nettype none
module dpt_mem (
   input  wire logic                        clock,
   input  wire logic                        we,
   input  wire logic [dpt_pkg::ADDR_W-1:0]  waddr,
   input  wire logic [dpt_pkg::WORD_W-1:0]  wdata,
   input  wire logic                        re,
   input  wire logic [dpt_pkg::ADDR_W-1:0]  raddr,
   output logic      [dpt_pkg::WORD_W-1:0]  rdata
);
   import dpt_pkg::*;

   logic [WORD_W-1:0] mem_ff [CELLS];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/dpt_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module dpt_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dpt_pkg::div_req_type req,
   output dpt_pkg::div_rsp_type      rsp
);
   import dpt_pkg::*;

   logic [31:0] quot_ff, quot_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[31]};
      if (req.start) begin
         quot_in = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = 16'(shifted - {1'b0, den_ff});
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted[15:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/delivery_predictability_table.sv =====
// top level: sequencer of the delivery predictability table
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    mode, node_a, node_b, now, alive_mask, coin
//   rsp_chan  out  valid/ready    forward, pred_a_sink
//   csr_*     in   csr_we only    csr_index, csr_wdata
//
// one word at a time; ready is high only while the sequencer is idle
// init: writes all 272 cells, one cell written a cycle
// aging one cell: the 32-step divider, then square-and-multiply on the
//   single shared multiplier
// encounter: the pair update, then up to 15 transitive columns; tick: up to 256 cell agings
// reset is synchronous; table contents are undefined until an init word
// the result sits in an output register; a stalled rsp_chan holds the next
//   word at the final read
`default_nettype none
`include "delivery_predictability_table_macros.svh"
module delivery_predictability_table (
   input  wire logic        clock,
   input  wire logic        reset,
   dpt_req_if.sink          req_chan,
   dpt_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import dpt_pkg::*;

   // sequencer states
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_INIT    = 5'd1;
   localparam logic [4:0] ST_TK_WAIT = 5'd2;
   localparam logic [4:0] ST_TK_SCAN = 5'd3;
   localparam logic [4:0] ST_TK_WR   = 5'd4;
   localparam logic [4:0] ST_EN_R1   = 5'd5;
   localparam logic [4:0] ST_EN_R2   = 5'd6;
   localparam logic [4:0] ST_EN_W2   = 5'd7;
   localparam logic [4:0] ST_TR_SCAN = 5'd8;
   localparam logic [4:0] ST_TR_A    = 5'd9;
   localparam logic [4:0] ST_TR_B    = 5'd10;
   localparam logic [4:0] ST_TR_MUL  = 5'd11;
   localparam logic [4:0] ST_SK_UPD  = 5'd12;
   localparam logic [4:0] ST_SK_WR   = 5'd13;
   localparam logic [4:0] ST_Q_A     = 5'd14;
   localparam logic [4:0] ST_Q_B     = 5'd15;
   localparam logic [4:0] ST_FIN_RD  = 5'd16;
   localparam logic [4:0] ST_FIN     = 5'd17;
   localparam logic [4:0] ST_AG_RD   = 5'd18;
   localparam logic [4:0] ST_AG_CHK  = 5'd19;
   localparam logic [4:0] ST_AG_DIV  = 5'd20;
   localparam logic [4:0] ST_PW_R    = 5'd21;
   localparam logic [4:0] ST_PW_B    = 5'd22;
   localparam logic [4:0] ST_PW_C    = 5'd23;
   localparam logic [4:0] ST_AG_END  = 5'd24;

   // configuration registers
   logic [15:0] reinf_ff, decay_pred_ff, trans_pred_ff, age_interval_ff;
   logic        strict_tie_ff;

   // control and datapath registers
   logic [4:0]        state_ff, state_in, ret_ff, ret_in;
   logic [2:0]        mode_ff, mode_in;
   logic [3:0]        a_ff, a_in, b_ff, b_in;
   logic [31:0]       now_ff, now_in;
   logic [15:0]       alive_ff, alive_in;
   logic              coin_ff, coin_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in, addr_ff, addr_in;
   logic [4:0]        row_ff, row_in, col_ff, col_in;
   logic [15:0]       pred_ff, pred_in, k_ff, k_in, aged_ff, aged_in;
   logic [15:0]       ab_ff, ab_in, pa_ff, pa_in, pb_ff, pb_in;
   logic [PROB_BITS:0] r_ff, r_in, base_ff, base_in;
   logic [2:0]        ph_ff, ph_in;
   logic              eq_ff, eq_in, fwd_ff, fwd_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_fwd_ff, rsp_fwd_in;
   logic [15:0]       rsp_pred_ff, rsp_pred_in;
   logic [2*PROB_BITS+1:0] prod_ff;

   // shared multiplier operands and products
   logic [PROB_BITS:0] mul_x, mul_y, pm;

   // memory and divider hookup
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;
   logic [31:0]       rd_stamp;
   logic [15:0]       rd_pred;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [15:0] iv;
   logic        accept;
   logic [3:0]  col_m1;
   logic        tk_valid, tr_valid;
   logic [4:0]  tk_row_nx, tk_col_nx;

   // p + g, where the caller passes g = (1 - p) * gain; clamped below 1.0
   function automatic logic [15:0] clamp_add(input logic [15:0] p,
                                             input logic [PROB_BITS:0] g);
      logic [PROB_BITS+1:0] s;
      s = {2'b00, p} + {1'b0, g};
      return (s >= {1'b0, PONE}) ? {PROB_BITS{1'b1}} : s[15:0];
   endfunction

   dpt_mem u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   dpt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rd_stamp = mem_rdata[WORD_W-1:PROB_BITS];
   assign rd_pred  = mem_rdata[PROB_BITS-1:0];
   assign pm       = prod_ff[2*PROB_BITS:PROB_BITS];
   // zero interval acts as one
   assign iv       = (age_interval_ff == 16'd0) ? 16'd1 : age_interval_ff;
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign col_m1   = 4'(col_ff - 5'd1);

   // tick walk: sink column of each alive row, then alive other nodes
   assign tk_valid = alive_ff[row_ff[3:0]] &&
                     ((col_ff == 5'd0) || (alive_ff[col_m1] && (col_m1 != row_ff[3:0])));
   assign tk_col_nx = (col_ff == 5'(NODES)) ? 5'd0 : col_ff + 5'd1;
   assign tk_row_nx = (col_ff == 5'(NODES)) ? row_ff + 5'd1 : row_ff;
   // transitive walk: sink column, then alive third nodes
   assign tr_valid = (col_ff == 5'd0) ||
                     (alive_ff[col_m1] && (col_m1 != a_ff) && (col_m1 != b_ff));

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;   mode_in = mode_ff;
      a_in = a_ff;          b_in = b_ff;       now_in = now_ff;
      alive_in = alive_ff;  coin_in = coin_ff; cnt_in = cnt_ff;
      addr_in = addr_ff;    row_in = row_ff;   col_in = col_ff;
      pred_in = pred_ff;    k_in = k_ff;       aged_in = aged_ff;
      ab_in = ab_ff;        pa_in = pa_ff;     pb_in = pb_ff;
      r_in = r_ff;          base_in = base_ff; ph_in = ph_ff;
      eq_in = eq_ff;        fwd_in = fwd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_fwd_in   = rsp_fwd_ff;
      rsp_pred_in  = rsp_pred_ff;
      mul_x = '0;
      mul_y = '0;
      mem_we = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = {now_ff, aged_ff};
      mem_re = 1'b0;
      mem_raddr = addr_ff;
      div_req.start = 1'b0;
      div_req.num   = now_ff;
      div_req.den   = iv;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_chan.mode;
               a_in     = req_chan.node_a;
               b_in     = req_chan.node_b;
               now_in   = req_chan.now;
               alive_in = req_chan.alive_mask;
               coin_in  = req_chan.coin;
               fwd_in   = 1'b0;
               case (req_chan.mode)
                  MODE_INIT: begin
                     cnt_in   = '0;
                     state_in = ST_INIT;
                  end
                  MODE_TICK: begin
                     div_req.start = 1'b1;
                     div_req.num   = req_chan.now;
                     state_in      = ST_TK_WAIT;
                  end
                  MODE_ENC: begin
                     if (req_chan.node_a == req_chan.node_b) begin
                        state_in = ST_FIN_RD;
                     end else begin
                        addr_in  = cell_addr(req_chan.node_a, {1'b0, req_chan.node_b} + 5'd1);
                        ret_in   = ST_EN_R1;
                        state_in = ST_AG_RD;
                     end
                  end
                  MODE_SINK: begin
                     addr_in  = cell_addr(req_chan.node_a, 5'd0);
                     ret_in   = ST_SK_UPD;
                     state_in = ST_AG_RD;
                  end
                  MODE_QUERY: begin
                     addr_in  = cell_addr(req_chan.node_a, 5'd0);
                     ret_in   = ST_Q_A;
                     state_in = ST_AG_RD;
                  end
                  default: begin
                     state_in = ST_FIN_RD;
                  end
               endcase
            end
         end
         // sweep every cell to the reinforcement constant at now
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = {now_ff, reinf_ff};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_FIN_RD;
            end
         end
         ST_TK_WAIT: begin
            if (div_rsp.done) begin
               row_in   = '0;
               col_in   = '0;
               state_in = (div_rsp.rem == 16'd0) ? ST_TK_SCAN : ST_FIN_RD;
            end
         end
         ST_TK_SCAN: begin
            if (row_ff == 5'(NODES)) begin
               state_in = ST_FIN_RD;
            end else if (tk_valid) begin
               addr_in  = cell_addr(row_ff[3:0], col_ff);
               ret_in   = ST_TK_WR;
               state_in = ST_AG_RD;
            end else begin
               row_in = tk_row_nx;
               col_in = tk_col_nx;
            end
         end
         ST_TK_WR: begin
            mem_we   = 1'b1;
            row_in   = tk_row_nx;
            col_in   = tk_col_nx;
            state_in = ST_TK_SCAN;
         end
         // encounter: repeated contact at the same time is skipped
         ST_EN_R1: begin
            if (eq_ff) begin
               state_in = ST_FIN_RD;
            end else begin
               mul_x    = PONE - {1'b0, aged_ff};
               mul_y    = {1'b0, reinf_ff};
               state_in = ST_EN_R2;
            end
         end
         ST_EN_R2: begin
            ab_in     = clamp_add(aged_ff, pm);
            mem_we    = 1'b1;
            mem_wdata = {now_ff, clamp_add(aged_ff, pm)};
            state_in  = ST_EN_W2;
         end
         // mirror entry gets the same value
         ST_EN_W2: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(b_ff, {1'b0, a_ff} + 5'd1);
            mem_wdata = {now_ff, ab_ff};
            col_in    = '0;
            state_in  = ST_TR_SCAN;
         end
         ST_TR_SCAN: begin
            if (col_ff == 5'(COLS)) begin
               state_in = ST_FIN_RD;
            end else if (tr_valid) begin
               addr_in  = cell_addr(a_ff, col_ff);
               ret_in   = ST_TR_A;
               state_in = ST_AG_RD;
            end else begin
               col_in = col_ff + 5'd1;
            end
         end
         ST_TR_A: begin
            pa_in    = aged_ff;
            addr_in  = cell_addr(b_ff, col_ff);
            ret_in   = ST_TR_B;
            state_in = ST_AG_RD;
         end
         ST_TR_B: begin
            pb_in    = aged_ff;
            mul_x    = {1'b0, ab_ff};
            mul_y    = {1'b0, aged_ff};
            ph_in    = 3'd0;
            state_in = ST_TR_MUL;
         end
         // both updates use the pre-update pa and pb
         ST_TR_MUL: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0, 3'd3: begin
                  mul_x = pm;
                  mul_y = {1'b0, trans_pred_ff};
               end
               3'd1: begin
                  mul_x = PONE - {1'b0, pa_ff};
                  mul_y = pm;
               end
               3'd2: begin
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(a_ff, col_ff);
                  mem_wdata = {now_ff, clamp_add(pa_ff, pm)};
                  mul_x     = {1'b0, ab_ff};
                  mul_y     = {1'b0, pa_ff};
               end
               3'd4: begin
                  mul_x = PONE - {1'b0, pb_ff};
                  mul_y = pm;
               end
               default: begin
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(b_ff, col_ff);
                  mem_wdata = {now_ff, clamp_add(pb_ff, pm)};
                  col_in    = col_ff + 5'd1;
                  state_in  = ST_TR_SCAN;
               end
            endcase
         end
         ST_SK_UPD: begin
            if (eq_ff) begin
               state_in = ST_FIN_RD;
            end else begin
               mul_x    = PONE - {1'b0, aged_ff};
               mul_y    = {1'b0, reinf_ff};
               state_in = ST_SK_WR;
            end
         end
         ST_SK_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {now_ff, clamp_add(aged_ff, pm)};
            state_in  = ST_FIN_RD;
         end
         ST_Q_A: begin
            mem_we   = 1'b1;
            pa_in    = aged_ff;
            addr_in  = cell_addr(b_ff, 5'd0);
            ret_in   = ST_Q_B;
            state_in = ST_AG_RD;
         end
         // tie: strict never forwards, otherwise the coin decides
         ST_Q_B: begin
            mem_we = 1'b1;
            if (aged_ff == pa_ff) begin
               fwd_in = strict_tie_ff ? 1'b0 : coin_ff;
            end else begin
               fwd_in = (aged_ff > pa_ff);
            end
            state_in = ST_FIN_RD;
         end
         ST_FIN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr(a_ff, 5'd0);
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_fwd_in   = fwd_ff;
               rsp_pred_in  = rd_pred;
               state_in     = ST_IDLE;
            end
         end
         // lazy aging of the cell at addr_ff, result in aged_ff
         ST_AG_RD: begin
            mem_re   = 1'b1;
            state_in = ST_AG_CHK;
         end
         ST_AG_CHK: begin
            pred_in = rd_pred;
            eq_in   = (rd_stamp == now_ff);
            if (rd_stamp == now_ff) begin
               aged_in  = rd_pred;
               state_in = ret_ff;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = now_ff - rd_stamp;
               state_in      = ST_AG_DIV;
            end
         end
         ST_AG_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quot == 32'd0) begin
                  aged_in  = pred_ff;
                  state_in = ret_ff;
               end else begin
                  k_in     = (div_rsp.quot[31:16] != 16'd0) ? 16'hFFFF : div_rsp.quot[15:0];
                  r_in     = PONE;
                  base_in  = {1'b0, decay_pred_ff};
                  state_in = ST_PW_R;
               end
            end
         end
         ST_PW_R: begin
            if (k_ff[0]) begin
               mul_x    = r_ff;
               mul_y    = base_ff;
               state_in = ST_PW_B;
            end else begin
               mul_x    = base_ff;
               mul_y    = base_ff;
               state_in = ST_PW_C;
            end
         end
         ST_PW_B: begin
            r_in     = pm;
            mul_x    = base_ff;
            mul_y    = base_ff;
            state_in = ST_PW_C;
         end
         ST_PW_C: begin
            base_in = pm;
            k_in    = {1'b0, k_ff[15:1]};
            if (k_ff[15:1] == 15'd0) begin
               mul_x    = {1'b0, pred_ff};
               mul_y    = r_ff;
               state_in = ST_AG_END;
            end else begin
               state_in = ST_PW_R;
            end
         end
         ST_AG_END: begin
            aged_in  = pm[15:0];
            state_in = ret_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         reinf_ff        <= RST_REINF_PRED;
         decay_pred_ff   <= RST_DECAY_PRED;
         trans_pred_ff   <= RST_TRANS_PRED;
         strict_tie_ff   <= RST_STRICT_TIE;
         age_interval_ff <= RST_AGE_INTERVAL;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_REINF_PRED:   reinf_ff        <= csr_wdata;
               CSR_DECAY_PRED:   decay_pred_ff   <= csr_wdata;
               CSR_TRANS_PRED:   trans_pred_ff   <= csr_wdata;
               CSR_STRICT_TIE:   strict_tie_ff   <= csr_wdata[0];
               CSR_AGE_INTERVAL: age_interval_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ret_ff  <= ret_in;   mode_ff <= mode_in;  a_ff <= a_in;       b_ff <= b_in;
      now_ff  <= now_in;   alive_ff <= alive_in; coin_ff <= coin_in; cnt_ff <= cnt_in;
      addr_ff <= addr_in;  row_ff <= row_in;    col_ff <= col_in;   pred_ff <= pred_in;
      k_ff    <= k_in;     aged_ff <= aged_in;  ab_ff <= ab_in;     pa_ff <= pa_in;
      pb_ff   <= pb_in;    r_ff <= r_in;        base_ff <= base_in; ph_ff <= ph_in;
      eq_ff   <= eq_in;    fwd_ff <= fwd_in;
      rsp_fwd_ff  <= rsp_fwd_in;
      rsp_pred_ff <= rsp_pred_in;
      prod_ff <= {{(PROB_BITS+1){1'b0}}, mul_x} * {{(PROB_BITS+1){1'b0}}, mul_y};
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.forward     = rsp_fwd_ff;
   assign rsp_chan.pred_a_sink = rsp_pred_ff;

   `DPT_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, state_ff != ST_IDLE, "idle after accept")
   `DPT_ASSERT_IMP(a_div_done_waited, clock, reset, div_rsp.done, (state_ff == ST_AG_DIV) || (state_ff == ST_TK_WAIT), "divider result unclaimed")
   `DPT_ASSERT_IMP(a_waddr_range, clock, reset, mem_we, mem_waddr < ADDR_W'(CELLS), "table write out of range")
   `DPT_ASSERT_IMP(a_fwd_query_only, clock, reset, (state_ff == ST_FIN) && fwd_ff, mode_ff == MODE_QUERY, "forward on a non-query word")
endmodule
`default_nettype wire
